// ===== hw/rtl/gmq_pkg.sv =====
// Gram matrix query engine: shared package.
// Field widths, register codes, opcodes, sequencer states and control structs.
// No dependencies.
package gmq_pkg;

  localparam int MaxVectorsDef = 64;
  localparam int MaxClassesDef = 32;

  localparam int RowW     = 6;
  localparam int ClassW   = 5;
  localparam int ProbW    = 16;
  localparam int ColW     = 7;
  localparam int ValueW   = 42;
  localparam int ProdW    = 2 * ProbW;
  localparam int VcW      = 7;
  localparam int CcW      = 6;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 8;

  localparam logic [VcW-1:0] VectorCountRst = VcW'(64);
  localparam logic [CcW-1:0] ClassCountRst  = CcW'(32);

  typedef enum logic [CfgIdxW-1:0] {
    CFG_VECTOR_COUNT = 2'd0,
    CFG_CLASS_COUNT  = 2'd1
  } cfg_reg_e;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_QUERY = 1'b1
  } opcode_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic clear;  // start of a new query
    logic valid;  // operands from the store are valid this cycle
  } mac_ctrl_t;

endpackage

// ===== hw/rtl/gmq_ifs.sv =====
// Gram matrix query engine: channel interfaces (request, response, config write).
// Depends on gmq_pkg.
interface gmq_req_if;
  import gmq_pkg::*;
  logic              valid;
  logic              ready;
  logic              opcode;
  logic [RowW-1:0]   vector_index;
  logic [ClassW-1:0] class_index;
  logic [ProbW-1:0]  prob_value;
  logic [ColW-1:0]   query_column;

  modport source (output valid, opcode, vector_index, class_index, prob_value, query_column,
                  input ready);
  modport sink   (input valid, opcode, vector_index, class_index, prob_value, query_column,
                  output ready);
endinterface

interface gmq_rsp_if;
  import gmq_pkg::*;
  logic              valid;
  logic              ready;
  logic [ValueW-1:0] matrix_value;
  logic [RowW-1:0]   out_row;
  logic [ColW-1:0]   out_column;
  logic              is_row_sum;
  logic              range_error;

  modport source (output valid, matrix_value, out_row, out_column, is_row_sum, range_error,
                  input ready);
  modport sink   (input valid, matrix_value, out_row, out_column, is_row_sum, range_error,
                  output ready);
endinterface

interface gmq_cfg_if;
  import gmq_pkg::*;
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/gmq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module gmq_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// ===== hw/rtl/gmq_mac.sv =====
// Shared multiply-accumulate unit: registered 16x16 product, saturating 42-bit sum.
// Depends on gmq_pkg.
module gmq_mac (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  gmq_pkg::mac_ctrl_t        ctrl_i,
  input  logic [gmq_pkg::ProbW-1:0] a_i,
  input  logic [gmq_pkg::ProbW-1:0] b_i,
  output logic [gmq_pkg::ValueW-1:0] acc_o,
  output logic                      busy_o
);
  import gmq_pkg::*;

  logic [ProdW-1:0]  prod_q, prod_d;
  logic              prod_v_q;
  logic [ValueW-1:0] acc_q, acc_d;
  logic [ValueW:0]   sum;

  assign prod_d = a_i * b_i;
  assign sum    = {1'b0, acc_q} + (ValueW + 1)'(prod_q);

  // sums only grow, so a sticky clamp equals clamping the exact total
  always_comb begin
    acc_d = acc_q;
    if (ctrl_i.clear) begin
      acc_d = '0;
    end else if (prod_v_q) begin
      acc_d = sum[ValueW] ? '1 : sum[ValueW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_v_q <= 1'b0;
      acc_q    <= '0;
    end else begin
      prod_v_q <= ctrl_i.valid;
      acc_q    <= acc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  assign acc_o  = acc_q;
  assign busy_o = prod_v_q;

endmodule

// ===== hw/rtl/gram_matrix_query_engine.sv =====
// Gram matrix query engine: store of Q1.15 probability vectors answering dot-product
// and row-sum queries. Top level: sequencer, element store, config registers.
// Depends on gmq_pkg, gmq_ifs, gmq_ram, gmq_mac.
//
// Channels: req_i carries load and query transactions, rsp_o returns one result per
// query, cfg_i writes vector_count (index 0) and class_count (index 1); cfg_i is
// always ready and must only be written while the block is idle.
// A load writes one element; it gives no result.
// A query runs nc*m multiply-accumulates, where nc is the effective class
// count and m is 1 for a single entry or the effective vector count for a row sum:
// one multiply-accumulate per cycle through the single shared MAC unit, reading both
// operands from two copies of the element store. A range error or a zero class
// count skips the accumulation. req_i.ready is low while a query is in progress.
// The result sits in an output register; the block keeps taking loads while it
// waits, but a finished query holds until rsp_o.ready frees the register.
// Reset sets vector_count to 64 and class_count to 32 and empties the channels;
// store contents are undefined until loaded.
module gram_matrix_query_engine #(
  parameter int MAX_VECTORS = gmq_pkg::MaxVectorsDef,
  parameter int MAX_CLASSES = gmq_pkg::MaxClassesDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  gmq_cfg_if.sink   cfg_i,
  gmq_req_if.sink   req_i,
  gmq_rsp_if.source rsp_o
);
  import gmq_pkg::*;

  localparam int Depth = MAX_VECTORS * MAX_CLASSES;
  localparam int AW    = $clog2(Depth);
  localparam logic [AW-1:0] ClassStride = AW'(MAX_CLASSES);

  state_e            state_q, state_d;
  logic [VcW-1:0]    vc_q, vc_d, eff_vc;
  logic [CcW-1:0]    cc_q, cc_d, eff_cc;
  logic [CcW-1:0]    k_q, k_d;
  logic [ColW-1:0]   j_q, j_d;
  logic [AW-1:0]     base_a_q, base_a_d, base_b_q, base_b_d;
  logic [RowW-1:0]   row_q, row_d;
  logic [ColW-1:0]   col_q, col_d;
  logic              rsum_q, rsum_d, err_q, err_d;
  logic              rd_v_q;
  logic              out_valid_q, out_valid_d, out_load;
  logic [ValueW-1:0] out_value_q;
  logic [RowW-1:0]   out_row_q;
  logic [ColW-1:0]   out_col_q;
  logic              out_rsum_q, out_err_q;

  logic              req_acc, load_we, query_err;
  logic [AW-1:0]     row_base, col_base, waddr, raddr_a, raddr_b;
  logic [ProbW-1:0]  rdata_a, rdata_b;
  logic [ValueW-1:0] acc;
  logic              mac_busy;
  mac_ctrl_t         mac_ctrl;

  // configuration registers
  assign cfg_i.ready = 1'b1;

  always_comb begin
    vc_d = vc_q;
    cc_d = cc_q;
    if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_VECTOR_COUNT: vc_d = cfg_i.data[VcW-1:0];
        CFG_CLASS_COUNT:  cc_d = cfg_i.data[CcW-1:0];
        default: ;
      endcase
    end
  end

  assign eff_vc = (32'(vc_q) > MAX_VECTORS) ? VcW'(MAX_VECTORS) : vc_q;
  assign eff_cc = (32'(cc_q) > MAX_CLASSES) ? CcW'(MAX_CLASSES) : cc_q;

  // request decode
  assign req_i.ready = (state_q == ST_IDLE);
  assign req_acc     = req_i.valid && req_i.ready;
  assign row_base    = AW'(32'(req_i.vector_index) * MAX_CLASSES);
  assign col_base    = AW'(32'(req_i.query_column) * MAX_CLASSES);
  assign waddr       = row_base + AW'(req_i.class_index);
  assign load_we     = req_acc && (req_i.opcode == OP_LOAD)
                    && (32'(req_i.vector_index) < MAX_VECTORS)
                    && (32'(req_i.class_index) < MAX_CLASSES);
  assign query_err   = (ColW'(req_i.vector_index) >= eff_vc) || (req_i.query_column > eff_vc);

  // sequencer
  always_comb begin
    state_d        = state_q;
    k_d            = k_q;
    j_d            = j_q;
    base_a_d       = base_a_q;
    base_b_d       = base_b_q;
    row_d          = row_q;
    col_d          = col_q;
    rsum_d         = rsum_q;
    err_d          = err_q;
    out_load       = 1'b0;
    mac_ctrl.clear = 1'b0;
    mac_ctrl.valid = rd_v_q;
    case (state_q)
      ST_IDLE: begin
        if (req_acc && (req_i.opcode == OP_QUERY)) begin
          mac_ctrl.clear = 1'b1;
          row_d    = req_i.vector_index;
          col_d    = req_i.query_column;
          err_d    = query_err;
          rsum_d   = !query_err && (req_i.query_column == eff_vc);
          k_d      = '0;
          j_d      = '0;
          base_a_d = row_base;
          base_b_d = (req_i.query_column == eff_vc) ? '0 : col_base;
          if (query_err || (eff_cc == '0)) begin
            state_d = ST_DONE;
          end else begin
            state_d = ST_RUN;
          end
        end
      end
      ST_RUN: begin
        if (k_q == eff_cc - CcW'(1)) begin
          k_d = '0;
          if (rsum_q && (j_q != eff_vc - VcW'(1))) begin
            j_d      = j_q + ColW'(1);
            base_b_d = base_b_q + ClassStride;
          end else begin
            state_d = ST_DRAIN;
          end
        end else begin
          k_d = k_q + CcW'(1);
        end
      end
      ST_DRAIN: begin
        // wait for the last operands to pass through the product register
        if (!rd_v_q && !mac_busy) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || rsp_o.ready) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  assign raddr_a = base_a_q + AW'(k_q);
  assign raddr_b = base_b_q + AW'(k_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      vc_q        <= VectorCountRst;
      cc_q        <= ClassCountRst;
      k_q         <= '0;
      j_q         <= '0;
      rsum_q      <= 1'b0;
      err_q       <= 1'b0;
      rd_v_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      vc_q        <= vc_d;
      cc_q        <= cc_d;
      k_q         <= k_d;
      j_q         <= j_d;
      rsum_q      <= rsum_d;
      err_q       <= err_d;
      rd_v_q      <= (state_q == ST_RUN);
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    base_a_q <= base_a_d;
    base_b_q <= base_b_d;
    row_q    <= row_d;
    col_q    <= col_d;
    if (out_load) begin
      out_value_q <= err_q ? '0 : acc;
      out_row_q   <= row_q;
      out_col_q   <= col_q;
      out_rsum_q  <= rsum_q;
      out_err_q   <= err_q;
    end
  end

  // two copies of the store give both operands in the same cycle
  gmq_ram #(
    .WIDTH(ProbW),
    .DEPTH(Depth)
  ) u_ram_a (
    .clk_i  (clk_i),
    .we_i   (load_we),
    .waddr_i(waddr),
    .wdata_i(req_i.prob_value),
    .raddr_i(raddr_a),
    .rdata_o(rdata_a)
  );

  gmq_ram #(
    .WIDTH(ProbW),
    .DEPTH(Depth)
  ) u_ram_b (
    .clk_i  (clk_i),
    .we_i   (load_we),
    .waddr_i(waddr),
    .wdata_i(req_i.prob_value),
    .raddr_i(raddr_b),
    .rdata_o(rdata_b)
  );

  gmq_mac u_mac (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .ctrl_i(mac_ctrl),
    .a_i   (rdata_a),
    .b_i   (rdata_b),
    .acc_o (acc),
    .busy_o(mac_busy)
  );

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.matrix_value = out_value_q;
  assign rsp_o.out_row      = out_row_q;
  assign rsp_o.out_column   = out_col_q;
  assign rsp_o.is_row_sum   = out_rsum_q;
  assign rsp_o.range_error  = out_err_q;

endmodule

// ===== hw/rtl/gmq_checker.sv =====
// Port-level checks for the gram matrix query engine, bound to the top level.
// Depends on gmq_pkg and gram_matrix_query_engine.
module gmq_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       req_valid_i,
  input logic                       req_ready_i,
  input logic                       req_opcode_i,
  input logic                       rsp_valid_i,
  input logic                       rsp_ready_i,
  input logic [gmq_pkg::ValueW-1:0] rsp_value_i,
  input logic                       rsp_row_sum_i,
  input logic                       rsp_err_i
);
  import gmq_pkg::*;

  logic req_acc;
  assign req_acc = req_valid_i && req_ready_i;

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i)
    else $error("response dropped while stalled");

  a_rsp_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> $stable(rsp_value_i))
    else $error("response value changed while stalled");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_err_i |-> (rsp_value_i == '0) && !rsp_row_sum_i)
    else $error("range error with nonzero value or row-sum flag");

  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_acc && (req_opcode_i == OP_QUERY) |=> !req_ready_i)
    else $error("request taken while a query is in progress");

  a_load_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_acc && (req_opcode_i == OP_LOAD) |=> !$rose(rsp_valid_i))
    else $error("load produced a response");

endmodule

bind gram_matrix_query_engine gmq_checker u_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .req_valid_i  (req_i.valid),
  .req_ready_i  (req_i.ready),
  .req_opcode_i (req_i.opcode),
  .rsp_valid_i  (rsp_o.valid),
  .rsp_ready_i  (rsp_o.ready),
  .rsp_value_i  (rsp_o.matrix_value),
  .rsp_row_sum_i(rsp_o.is_row_sum),
  .rsp_err_i    (rsp_o.range_error)
);
